@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside of reset.
`define SDT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition seen now must be followed by the given one on the next edge.
`define SDT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) \
        else $error(msg);

`endif

@@ design/sdt_pkg.sv @@
package sdt_pkg;

    // command codes on the request tuser
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_SET   = 2'd2;

    // highest entry count the 11-bit granted selector can name
    localparam int SEL_REACH = 256;
    // entries checked per scan step
    localparam int GRP_W = 16;

    localparam logic [31:0] LIMIT_MAX  = 32'h000F_FFFF;
    localparam int          PAGE_SHIFT = 12;
    localparam logic [15:0] GRAN_BIT   = 16'h8000;
    localparam logic [63:0] ATTR_MASK  = 64'h00FF_FF00_0000_0000;

    typedef struct packed {
        logic start;     // begin a free-entry scan
        logic upd_en;    // write one busy bit
        logic upd_busy;  // new busy value
    } t_scan_ctl;

    typedef struct packed {
        logic       done;   // one-cycle pulse, scan finished
        logic       found;
        logic [7:0] idx;    // entry index of the first free entry
    } t_scan_res;

    // Standard descriptor layout; large limits switch to 4 KiB granularity.
    function automatic logic [63:0] pack_desc(input logic [31:0] base,
                                              input logic [31:0] limit,
                                              input logic [15:0] attr);
        logic [31:0] lim;
        logic [15:0] a;
        lim = limit;
        a   = attr;
        if (limit > LIMIT_MAX) begin
            a   = a | GRAN_BIT;
            lim = limit >> PAGE_SHIFT;
        end
        a = a | {4'b0000, lim[19:16], 8'h00};
        return {base[31:24], a, base[23:0], lim[15:0]};
    endfunction

endpackage

@@ design/sdt_store.sv @@
module sdt_store #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sdt_alloc.sv @@
`include "assert_macros.svh"

module sdt_alloc #(
    parameter int SCAN_ENTRIES = 256,
    localparam int BW   = $clog2(SCAN_ENTRIES),
    localparam int NGRP = (SCAN_ENTRIES + sdt_pkg::GRP_W - 1) / sdt_pkg::GRP_W,
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1,
    localparam int PAD  = NGRP * sdt_pkg::GRP_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdt_pkg::t_scan_ctl i_ctl,
    input  logic [BW-1:0]     i_upd_idx,
    output sdt_pkg::t_scan_res o_res
);

    // one bit per scannable entry: attribute half-word nonzero
    logic [SCAN_ENTRIES-1:0] r_busy;
    logic [PAD-1:0]          busy_pad;
    logic [GW-1:0]           r_grp;
    logic                    r_run;
    logic                    r_done;
    logic                    r_found;
    logic [7:0]              r_idx;

    logic [sdt_pkg::GRP_W-1:0] grp_bits;
    logic [3:0]                enc;
    logic                      hit;
    logic                      last;
    logic [GW+3:0]             hit_idx;

    // entry 0 and padding past the table never count as free
    for (genvar p = 0; p < PAD; p++) begin : g_pad
        if (p == 0 || p >= SCAN_ENTRIES) begin : g_fixed
            assign busy_pad[p] = 1'b1;
        end else begin : g_live
            assign busy_pad[p] = r_busy[p];
        end
    end

    always_comb begin
        grp_bits = busy_pad[{r_grp, 4'b0000} +: sdt_pkg::GRP_W];
        enc      = '0;
        for (int k = sdt_pkg::GRP_W - 1; k >= 0; k--) begin
            if (!grp_bits[k]) begin
                enc = 4'(k);
            end
        end
        hit     = ~&grp_bits;
        last    = (r_grp == GW'(NGRP - 1));
        hit_idx = {r_grp, enc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.upd_en) begin
                r_busy[i_upd_idx] <= i_ctl.upd_busy;
            end
            if (i_ctl.start) begin
                r_run <= 1'b1;
            end else if (r_run && (hit || last)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_grp <= '0;
        end else if (r_run) begin
            r_grp   <= r_grp + GW'(1);
            r_found <= hit;
            r_idx   <= 8'(hit_idx);
        end
    end

    assign o_res = '{done: r_done, found: r_found, idx: r_idx};

    `SDT_ASSERT(a_start_idle, i_ctl.start |-> !r_run, "scan restarted while running")
    `SDT_ASSERT(a_never_entry0, (r_done && r_found) |-> (r_idx != 8'd0), "entry 0 granted")
    `SDT_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "scan done held for two cycles")

endmodule

@@ design/segment_descriptor_table_core.sv @@
// Segment descriptor table: 64-bit x86 descriptors in one synchronous RAM.
// Request channel (s_axis_*): tuser carries the command (allocate, free,
// set), tdata the selector, base, limit and attribute half-word.
// Response channel (m_axis_*): one response per request, tuser = status
// (1 = allocate found no free entry), tdata = granted selector and the
// packed descriptor word (nonzero only for set).
// Requests are taken one at a time. Set writes the RAM during decode; set
// and unused codes then go straight to the done state. Free reads the RAM,
// then writes the entry back with the attribute half-word cleared. Allocate
// scans the busy bitmap in 16-entry groups, passing over every group before
// the one holding the first free entry, at most 15 groups for a 256-entry
// table. With a ready receiver the next request is taken on the same edge
// that takes the response.
// Allocate never touches the RAM: a busy bitmap beside it, one bit per entry
// below 256, is scanned 16 entries per cycle with a priority encoder.
// Reset clears the bitmap at once, then a clearing pass zeroes the RAM one
// entry per cycle, through every entry, while s_axis_tready stays low.
// A finished response waits in an output register; if the receiver stalls,
// the next request is still accepted and worked on, and only its final
// handoff waits until the output register is free.
`include "assert_macros.svh"

module segment_descriptor_table_core #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [10:0] selector, [42:11] base, [74:43] limit, [90:75] attributes
    input  logic [95:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [10:0] granted_selector, [74:11] descriptor_word
    output logic [79:0] m_axis_tdata,
    // [0] status
    output logic [0:0]  m_axis_tuser
);

    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int SCAN = (TABLE_ENTRIES < sdt_pkg::SEL_REACH) ? TABLE_ENTRIES
                                                               : sdt_pkg::SEL_REACH;
    localparam int BW   = $clog2(SCAN);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DECODE = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_RMW    = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // request fields
    logic [1:0]  r_cmd;
    logic [7:0]  r_idx;
    logic [31:0] r_base;
    logic [31:0] r_limit;
    logic [15:0] r_attr;

    // response being built, and the output register
    logic        r_status;
    logic [10:0] r_granted;
    logic [63:0] r_word;
    logic        r_out_valid;
    logic [0:0]  r_out_user;
    logic [79:0] r_out_data;

    logic [IW-1:0] r_clr;

    logic          req_take;
    logic          out_free;
    logic          out_load;
    logic [IW+7:0] idx_ext;
    logic          in_table;
    logic          in_scan;
    logic [63:0]   packed_word;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic          mem_re;
    logic [63:0]   mem_rdata;

    sdt_pkg::t_scan_ctl scan_ctl;
    sdt_pkg::t_scan_res scan_res;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign req_take      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = (r_state == ST_DONE) && out_free;

    // entry index is selector / 8; widen before comparing against the depth
    assign idx_ext     = {{IW{1'b0}}, r_idx};
    assign in_table    = idx_ext < (IW + 8)'(TABLE_ENTRIES);
    assign in_scan     = {1'b0, r_idx} < 9'(SCAN);
    assign packed_word = sdt_pkg::pack_desc(r_base, r_limit, r_attr);

    // Memory and bitmap port control. Accesses to one entry never overlap:
    // each request finishes its write before the next request is decoded.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_ext[IW-1:0];
        mem_wdata = packed_word;
        mem_re    = 1'b0;
        scan_ctl  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            ST_DECODE: begin
                unique case (r_cmd)
                    sdt_pkg::CMD_ALLOC: begin
                        scan_ctl.start = 1'b1;
                    end
                    sdt_pkg::CMD_FREE: begin
                        mem_re            = in_table;
                        scan_ctl.upd_en   = in_scan;
                        scan_ctl.upd_busy = 1'b0;
                    end
                    sdt_pkg::CMD_SET: begin
                        mem_we            = in_table;
                        scan_ctl.upd_en   = in_scan;
                        scan_ctl.upd_busy = |(packed_word & sdt_pkg::ATTR_MASK);
                    end
                    default: begin
                    end
                endcase
            end
            ST_RMW: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~sdt_pkg::ATTR_MASK;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == IW'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_take) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (r_cmd)
                    sdt_pkg::CMD_ALLOC: n_state = ST_SCAN;
                    sdt_pkg::CMD_FREE:  n_state = in_table ? ST_RMW : ST_DONE;
                    default:            n_state = ST_DONE;
                endcase
            end
            ST_SCAN: begin
                if (scan_res.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_RMW: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_cmd   <= s_axis_tuser;
            r_idx   <= s_axis_tdata[10:3];
            r_base  <= s_axis_tdata[42:11];
            r_limit <= s_axis_tdata[74:43];
            r_attr  <= s_axis_tdata[90:75];
        end
        if (r_state == ST_DECODE) begin
            r_status  <= 1'b0;
            r_granted <= '0;
            r_word    <= (r_cmd == sdt_pkg::CMD_SET) ? packed_word : 64'd0;
        end
        if (r_state == ST_SCAN && scan_res.done) begin
            r_status  <= !scan_res.found;
            r_granted <= scan_res.found ? {scan_res.idx, 3'b000} : 11'd0;
        end
        if (out_load) begin
            r_out_user <= r_status;
            r_out_data <= {5'b00000, r_word, r_granted};
        end
    end

    sdt_store #(
        .DEPTH (TABLE_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (idx_ext[IW-1:0]),
        .o_rdata (mem_rdata)
    );

    sdt_alloc #(
        .SCAN_ENTRIES (SCAN)
    ) u_alloc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_upd_idx (r_idx[BW-1:0]),
        .o_res     (scan_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `SDT_ASSERT(a_idle_no_write, (r_state == ST_IDLE) |-> !mem_we, "RAM write while idle")
    `SDT_ASSERT(a_done_in_scan, scan_res.done |-> (r_state == ST_SCAN), "stray scan result")
    `SDT_ASSERT(a_fail_no_grant, (r_out_valid && r_out_user[0]) |-> (r_out_data[10:0] == 11'd0), "failed alloc with selector")

endmodule
